// ----- hdl/mrfe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mrfe_pkg
// Shared types, constants and helper functions for the Modbus read-response
// field extractor.
// ----------------------------------------------------------------------------
package mrfe_pkg;

  localparam int BUFFER_BYTES_DEF = 256;
  localparam int CELLS_DEF        = 16;

  localparam int FIXED_FIELDS = 17;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 8;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_SLAVE_ADDRESS  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_REGISTER_COUNT = 1'b1;

  localparam logic [7:0]  SLAVE_ADDRESS_RST  = 8'h01;
  localparam logic [6:0]  REGISTER_COUNT_RST = 7'd100;
  localparam logic [7:0]  FUNC_READ_HOLDING  = 8'h03;
  localparam logic [15:0] CRC_INIT           = 16'hFFFF;
  localparam logic [15:0] CRC_POLY           = 16'hA001;
  localparam logic [7:0]  PAYLOAD_BASE       = 8'd3;
  localparam logic [9:0]  FRAME_OVERHEAD     = 10'd5;

  // Result status codes.
  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_CRC   = 2'd2;

  typedef enum logic [1:0] {
    FK_UNSIGNED,
    FK_SIGNED16,
    FK_SIGNED32,
    FK_FLAG
  } field_kind_t;

  typedef struct packed {
    logic [7:0]  addr;   // frame byte position of the most significant byte
    logic [1:0]  nlast;  // byte count minus one
    field_kind_t kind;
  } field_desc_t;

  typedef struct packed {
    logic       go;      // a frame closed in this cycle
    logic [1:0] status;
  } frame_done_t;

  typedef enum logic [1:0] {
    EX_IDLE,
    EX_READ,
    EX_SHIFT,
    EX_PUT
  } ex_state_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic field_desc_t mk_desc(input logic [7:0] off, input logic [1:0] nlast,
                                          input field_kind_t kind);
    field_desc_t d;
    d.addr  = off + PAYLOAD_BASE;
    d.nlast = nlast;
    d.kind  = kind;
    return d;
  endfunction

  // The seventeen fixed fields that follow the cell voltages.
  function automatic field_desc_t fixed_field(input logic [4:0] j);
    field_desc_t d;
    unique case (j)
      5'd0:    d = mk_desc(8'h44, 2'd1, FK_UNSIGNED);
      5'd1:    d = mk_desc(8'h46, 2'd1, FK_UNSIGNED);
      5'd2:    d = mk_desc(8'h48, 2'd0, FK_UNSIGNED);
      5'd3:    d = mk_desc(8'h49, 2'd0, FK_UNSIGNED);
      5'd4:    d = mk_desc(8'h8A, 2'd1, FK_SIGNED16);
      5'd5:    d = mk_desc(8'h90, 2'd3, FK_UNSIGNED);
      5'd6:    d = mk_desc(8'h94, 2'd3, FK_UNSIGNED);
      5'd7:    d = mk_desc(8'h98, 2'd3, FK_SIGNED32);
      5'd8:    d = mk_desc(8'h9C, 2'd1, FK_SIGNED16);
      5'd9:    d = mk_desc(8'h9E, 2'd1, FK_SIGNED16);
      5'd10:   d = mk_desc(8'hA7, 2'd0, FK_UNSIGNED);
      5'd11:   d = mk_desc(8'hA8, 2'd3, FK_SIGNED32);
      5'd12:   d = mk_desc(8'hAC, 2'd3, FK_UNSIGNED);
      5'd13:   d = mk_desc(8'hB0, 2'd3, FK_UNSIGNED);
      5'd14:   d = mk_desc(8'hB4, 2'd3, FK_UNSIGNED);
      5'd15:   d = mk_desc(8'hC0, 2'd0, FK_FLAG);
      default: d = mk_desc(8'hC1, 2'd0, FK_FLAG);
    endcase
    return d;
  endfunction

  function automatic logic [32:0] format_value(input field_kind_t kind, input logic [31:0] acc);
    logic [32:0] v;
    unique case (kind)
      FK_UNSIGNED: v = {1'b0, acc};
      FK_SIGNED16: v = {{17{acc[15]}}, acc[15:0]};
      FK_SIGNED32: v = {acc[31], acc};
      FK_FLAG:     v = {32'd0, (acc[7:0] == 8'd1)};
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/mrfe_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mrfe_store
// Frame byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mrfe_store #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mrfe_intake.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mrfe_intake
// Byte intake: counts and stores frame bytes, runs the CRC, checks the header
// and judges the frame when its last byte arrives.
// ----------------------------------------------------------------------------
module mrfe_intake
  import mrfe_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int AW           = $clog2(BUFFER_BYTES),
  parameter int CW           = $clog2(BUFFER_BYTES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          end_of_frame,
  input  wire logic          busy,
  input  wire logic [7:0]    slave_address,
  input  wire logic [6:0]    register_count,
  output logic               wr_en,
  output logic      [AW-1:0] wr_addr,
  output logic      [7:0]    wr_data,
  output frame_done_t        done
);

  logic [CW-1:0] byte_count, byte_count_next;
  logic [15:0]   running_crc, running_crc_next;
  logic [15:0]   held_bytes, held_bytes_next;
  logic          header_ok, header_ok_next;
  logic          room, accept;
  logic [10:0]   min_len;
  logic [15:0]   crc_received;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign room     = byte_count < CW'(BUFFER_BYTES);

  assign wr_en   = accept && room;
  assign wr_addr = byte_count[AW-1:0];
  assign wr_data = rx_byte;

  // Values after this byte; a byte past the buffer leaves everything alone.
  always_comb begin
    byte_count_next  = byte_count;
    running_crc_next = running_crc;
    held_bytes_next  = held_bytes;
    header_ok_next   = header_ok;
    if (room) begin
      byte_count_next = byte_count + CW'(1);
      held_bytes_next = {held_bytes[7:0], rx_byte};
      if (byte_count == CW'(0) && rx_byte != slave_address) begin
        header_ok_next = 1'b0;
      end
      if (byte_count == CW'(1) && rx_byte != FUNC_READ_HOLDING) begin
        header_ok_next = 1'b0;
      end
      if (byte_count >= CW'(2)) begin
        running_crc_next = crc_feed(running_crc, held_bytes[15:8]);
      end
    end
  end

  // The CRC travels low byte first, so the held pair is swapped.
  assign crc_received = {held_bytes_next[7:0], held_bytes_next[15:8]};
  assign min_len      = 11'(FRAME_OVERHEAD) + {3'b000, register_count, 1'b0};

  always_comb begin
    done.go = accept && end_of_frame;
    priority if (11'(byte_count_next) < min_len || !header_ok_next) begin
      done.status = ST_SHORT;
    end else if (crc_received != running_crc_next) begin
      done.status = ST_CRC;
    end else begin
      done.status = ST_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_crc <= CRC_INIT;
      held_bytes  <= '0;
      header_ok   <= 1'b1;
    end else if (accept) begin
      if (end_of_frame) begin
        byte_count  <= '0;
        running_crc <= CRC_INIT;
        held_bytes  <= '0;
        header_ok   <= 1'b1;
      end else begin
        byte_count  <= byte_count_next;
        running_crc <= running_crc_next;
        held_bytes  <= held_bytes_next;
        header_ok   <= header_ok_next;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mrfe_extract.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mrfe_extract
// Field sequencer: reads each field byte by byte from the store, assembles
// it big-endian and hands it to the output register.
// ----------------------------------------------------------------------------
module mrfe_extract
  import mrfe_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int CELLS        = CELLS_DEF,
  parameter int AW           = $clog2(BUFFER_BYTES)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire frame_done_t        done,
  output logic                    busy,
  output logic                    rd_en,
  output logic           [AW-1:0] rd_addr,
  input  wire logic      [7:0]    rd_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic           [1:0]    frame_status,
  output logic           [5:0]    field_id,
  output logic signed    [32:0]   field_value,
  output logic                    last_result
);

  localparam logic [5:0] LAST_ID = 6'(CELLS + FIXED_FIELDS - 1);

  ex_state_t   state, state_next;
  logic [1:0]  status_r;
  logic [5:0]  fld;
  logic [1:0]  bidx;
  logic [31:0] acc;
  field_desc_t desc;
  logic        out_free, out_load, is_last;

  assign out_free = !out_valid || out_ready;
  assign is_last  = (status_r != ST_VALID) || (fld == LAST_ID);
  assign busy     = (state != EX_IDLE);

  always_comb begin
    if (fld < 6'(CELLS)) begin
      desc.addr  = PAYLOAD_BASE + {1'b0, fld, 1'b0};
      desc.nlast = 2'd1;
      desc.kind  = FK_UNSIGNED;
    end else begin
      desc = fixed_field(5'(fld - 6'(CELLS)));
    end
  end

  assign rd_addr = AW'(desc.addr) + AW'(bidx);

  always_comb begin
    state_next = state;
    unique case (state)
      EX_IDLE: begin
        if (done.go) begin
          state_next = (done.status == ST_VALID) ? EX_READ : EX_PUT;
        end
      end
      EX_READ:  state_next = EX_SHIFT;
      EX_SHIFT: state_next = (bidx == desc.nlast) ? EX_PUT : EX_READ;
      EX_PUT: begin
        if (out_free) begin
          state_next = is_last ? EX_IDLE : EX_READ;
        end
      end
    endcase
  end

  always_comb begin
    rd_en    = (state == EX_READ);
    out_load = (state == EX_PUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EX_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == EX_IDLE && done.go) begin
      status_r <= done.status;
      fld      <= '0;
      bidx     <= '0;
      acc      <= '0;
    end else if (state == EX_SHIFT) begin
      acc  <= {acc[23:0], rd_data};
      bidx <= bidx + 2'd1;
    end else if (out_load) begin
      fld  <= fld + 6'd1;
      bidx <= '0;
      acc  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      frame_status <= status_r;
      last_result  <= is_last;
      if (status_r == ST_VALID) begin
        field_id    <= fld;
        field_value <= format_value(desc.kind, acc);
      end else begin
        field_id    <= '0;
        field_value <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/modbus_read_response_field_extractor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_read_response_field_extractor
// Parses a received Modbus RTU read-holding-registers response byte by byte
// and, at frame end, emits either one error item or the run of fields.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    rx_byte, end_of_frame
// out      output     out_valid/out_ready  frame_status, field_id, field_value,
//                                          last_result
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A byte that does not close a frame is taken at once while the sequencer is
// idle, and the next byte may follow immediately. The byte that closes a frame
// starts the field sequencer, and no byte is taken until it has handed off the
// last result. Each field is read byte by byte on the store's single read port,
// each byte in an issue step and a capture step, and is then loaded into the
// output register; an error frame goes straight to that load step.
// A stalled output simply holds the sequencer in its load step. Reset clears
// the frame counters and restores the configuration registers; the byte store
// is not cleared, and no clearing pass is needed.
//
// The store is written only while the sequencer is idle and read only while
// it runs, so no forwarding path is needed between the two ports.
// ----------------------------------------------------------------------------
module modbus_read_response_field_extractor
  import mrfe_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int CELLS        = CELLS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             rx_byte,
  input  wire logic                   end_of_frame,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [1:0]             frame_status,
  output logic      [5:0]             field_id,
  output logic signed [32:0]          field_value,
  output logic                        last_result,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(BUFFER_BYTES);

  logic [7:0]    slave_address;
  logic [6:0]    register_count;
  logic          busy;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;
  frame_done_t   done;

  // Always taken; the user must issue configuration writes only while idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address  <= SLAVE_ADDRESS_RST;
      register_count <= REGISTER_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SLAVE_ADDRESS:  slave_address  <= cfg_data;
        REG_REGISTER_COUNT: register_count <= cfg_data[6:0];
      endcase
    end
  end

  mrfe_intake #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .AW          (AW)
  ) u_intake (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .end_of_frame  (end_of_frame),
    .busy          (busy),
    .slave_address (slave_address),
    .register_count(register_count),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .done          (done)
  );

  mrfe_store #(
    .DEPTH(BUFFER_BYTES),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  mrfe_extract #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .CELLS       (CELLS),
    .AW          (AW)
  ) u_extract (
    .clk         (clk),
    .rst         (rst),
    .done        (done),
    .busy        (busy),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_status(frame_status),
    .field_id    (field_id),
    .field_value (field_value),
    .last_result (last_result)
  );

endmodule
`default_nettype wire

// ----- verif/modbus_read_response_field_extractor_tb.sv -----
// ----------------------------------------------------------------------------
// Testbench for the Modbus read-response field extractor
// Feeds whole response frames, one byte per item, through the byte channel
// while the result side stalls at random. A scoreboard keeps its own copy of
// the frame state and the byte store, predicts every result item of each
// frame and checks the results field by field, in order.
// ----------------------------------------------------------------------------
module modbus_read_response_field_extractor_tb;
  import mrfe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CELLS     = CELLS_DEF;
  localparam int STORE_BYTES   = BUFFER_BYTES_DEF;
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD     = 400;
  localparam int IDLE_LIMIT    = 3000;
  localparam int PHASE_BYTES   = 30;

  // Frame positions of the two switch flags (payload offsets 0xC0 and 0xC1).
  localparam int CHARGE_FLAG_POS    = PAYLOAD_BASE + 'hC0;
  localparam int DISCHARGE_FLAG_POS = PAYLOAD_BASE + 'hC1;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [1:0]  status;
    logic [5:0]  id;
    logic [32:0] value;
    logic        last;
  } field_result_t;

  typedef struct {
    int unsigned offset;
    int unsigned nbytes;
    field_kind_t kind;
  } field_layout_t;

  typedef enum int {
    FILL_ZERO,
    FILL_ONES,
    FILL_RANDOM
  } fill_e;

  typedef enum int {
    SINK_OPEN,
    SINK_COIN,
    SINK_EVERY_THIRD,
    SINK_MOSTLY
  } sink_mode_e;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the frame parser and holds the results still owed.
  // --------------------------------------------------------------------------
  class frame_field_scoreboard;
    logic [7:0]    frame_bytes[STORE_BYTES];
    int unsigned   rx_count;
    logic [15:0]   crc_acc;
    logic [15:0]   tail_pair;
    bit            header_good;
    logic [7:0]    slave_addr;
    logic [6:0]    reg_count;
    field_result_t pending_fields[$];
    int unsigned   fault_count;

    function new();
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      slave_addr  = SLAVE_ADDRESS_RST;
      reg_count   = REGISTER_COUNT_RST;
      fault_count = 0;
      clear_frame();
    endfunction

    static function logic [15:0] crc_next(logic [15:0] crc, logic [7:0] data);
      logic [15:0] r;
      r = crc ^ {8'h00, data};
      repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY : 16'h0000);
      return r;
    endfunction

    function void clear_frame();
      rx_count    = 0;
      crc_acc     = CRC_INIT;
      tail_pair   = 16'h0000;
      header_good = 1'b1;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [7:0] data);
      case (idx)
        REG_SLAVE_ADDRESS:  slave_addr = data;
        REG_REGISTER_COUNT: reg_count = data[6:0];
        default: ;
      endcase
    endfunction

    // Big-endian read of nbytes store bytes starting at a payload offset.
    function logic [31:0] gather(int unsigned off, int unsigned nbytes);
      logic [31:0] raw;
      raw = 32'd0;
      for (int unsigned k = 0; k < nbytes; k++)
        raw = {raw[23:0], frame_bytes[PAYLOAD_BASE + off + k]};
      return raw;
    endfunction

    function field_layout_t fixed_layout(int unsigned j);
      field_layout_t l;
      case (j)
        0:       l = '{'h44, 2, FK_UNSIGNED};  // cell average
        1:       l = '{'h46, 2, FK_UNSIGNED};  // largest cell difference
        2:       l = '{'h48, 1, FK_UNSIGNED};  // index of highest cell
        3:       l = '{'h49, 1, FK_UNSIGNED};  // index of lowest cell
        4:       l = '{'h8A, 2, FK_SIGNED16};  // MOSFET temperature
        5:       l = '{'h90, 4, FK_UNSIGNED};  // pack voltage
        6:       l = '{'h94, 4, FK_UNSIGNED};  // power
        7:       l = '{'h98, 4, FK_SIGNED32};  // current
        8:       l = '{'h9C, 2, FK_SIGNED16};  // battery temperature 1
        9:       l = '{'h9E, 2, FK_SIGNED16};  // battery temperature 2
        10:      l = '{'hA7, 1, FK_UNSIGNED};  // state of charge
        11:      l = '{'hA8, 4, FK_SIGNED32};  // remaining capacity
        12:      l = '{'hAC, 4, FK_UNSIGNED};  // full charge capacity
        13:      l = '{'hB0, 4, FK_UNSIGNED};  // cycle count
        14:      l = '{'hB4, 4, FK_UNSIGNED};  // cycle capacity
        15:      l = '{'hC0, 1, FK_FLAG};      // charge switch
        default: l = '{'hC1, 1, FK_FLAG};      // discharge switch
      endcase
      return l;
    endfunction

    function logic [32:0] fixed_value(int unsigned j);
      field_layout_t l;
      logic [31:0]   raw;
      logic [32:0]   v;
      l   = fixed_layout(j);
      raw = gather(l.offset, l.nbytes);
      case (l.kind)
        FK_SIGNED16: v = {{17{raw[15]}}, raw[15:0]};
        FK_SIGNED32: v = {raw[31], raw};
        FK_FLAG:     v = (raw[7:0] == 8'd1) ? 33'd1 : 33'd0;
        default:     v = {1'b0, raw};
      endcase
      return v;
    endfunction

    // Takes one accepted byte; at frame end queues the results it owes.
    function void note_byte(logic [7:0] data, logic eof);
      logic [15:0] received;
      logic [1:0]  status;
      if (rx_count < STORE_BYTES) begin
        frame_bytes[rx_count] = data;
        if (rx_count == 0 && data != slave_addr) header_good = 1'b0;
        if (rx_count == 1 && data != FUNC_READ_HOLDING) header_good = 1'b0;
        if (rx_count >= 2) crc_acc = crc_next(crc_acc, tail_pair[15:8]);
        tail_pair = {tail_pair[7:0], data};
        rx_count++;
      end
      if (!eof) return;
      received = {tail_pair[7:0], tail_pair[15:8]};
      if (rx_count < FRAME_OVERHEAD + 2 * reg_count || !header_good)
        status = ST_SHORT;
      else if (received != crc_acc)
        status = ST_CRC;
      else
        status = ST_VALID;
      if (status != ST_VALID) begin
        pending_fields.push_back('{status, 6'd0, 33'd0, 1'b1});
      end else begin
        for (int unsigned c = 0; c < NUM_CELLS; c++)
          pending_fields.push_back('{ST_VALID, 6'(c), {1'b0, gather(2 * c, 2)}, 1'b0});
        for (int unsigned j = 0; j < FIXED_FIELDS; j++)
          pending_fields.push_back('{ST_VALID, 6'(NUM_CELLS + j), fixed_value(j),
                                     j == FIXED_FIELDS - 1});
      end
      clear_frame();
    endfunction

    function void check_field(logic [1:0] status, logic [5:0] id, logic [32:0] value,
                              logic last);
      field_result_t want;
      if (pending_fields.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t: result with none pending: status %0d id %0d value %h last %b",
                   $realtime, status, id, value, last);
        return;
      end
      want = pending_fields.pop_front();
      if (want.status !== status || want.id !== id || want.value !== value ||
          want.last !== last) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t: expected status %0d id %0d value %h last %b, got %0d %0d %h %b",
                   $realtime, want.status, want.id, want.value, want.last,
                   status, id, value, last);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test and its connections.
  // --------------------------------------------------------------------------
  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             rx_byte;
  logic                   end_of_frame;
  logic                   out_valid;
  logic                   out_ready;
  logic [1:0]             frame_status;
  logic [5:0]             field_id;
  logic signed [32:0]     field_value;
  logic                   last_result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  frame_field_scoreboard sb;

  int burst_left   = 0;
  int holds_asked  = 0;
  int holds_served = 0;
  int quiet_cycles = 0;

  modbus_read_response_field_extractor dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .end_of_frame (end_of_frame),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_status (frame_status),
    .field_id     (field_id),
    .field_value  (field_value),
    .last_result  (last_result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Frame construction. A frame is the slave id, the function code, a body
  // and the CRC of everything before it, low byte first.
  // --------------------------------------------------------------------------
  function automatic byte_q_t frame_body(logic [7:0] addr, logic [7:0] func,
                                         int unsigned nbytes, fill_e fill);
    byte_q_t     q;
    logic [7:0]  b;
    q.push_back(addr);
    q.push_back(func);
    for (int unsigned p = 2; p < nbytes; p++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom);
      endcase
      // Keep the switch flags near the value that turns them on, otherwise
      // random bytes would almost never set them.
      if (p == CHARGE_FLAG_POS || p == DISCHARGE_FLAG_POS) begin
        if (fill == FILL_ZERO) b = 8'h01;
        else if (fill == FILL_RANDOM) b = 8'($urandom_range(0, 2));
      end
      q.push_back(b);
    end
    return q;
  endfunction

  function automatic byte_q_t sealed(byte_q_t body, bit corrupt);
    byte_q_t     q;
    logic [15:0] crc;
    q   = body;
    crc = CRC_INIT;
    foreach (body[i]) crc = frame_field_scoreboard::crc_next(crc, body[i]);
    if (corrupt) crc[7:0] = crc[7:0] ^ 8'($urandom_range(1, 255));
    q.push_back(crc[7:0]);
    q.push_back(crc[15:8]);
    return q;
  endfunction

  function automatic byte_q_t noise(int unsigned nbytes);
    byte_q_t q;
    repeat (nbytes) q.push_back(8'($urandom));
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Byte channel driver. Payload changes at the falling edge; acceptance is
  // seen at the rising edge. The sender works in bursts: when a burst runs
  // out, valid drops for a random pause before the next item is offered. Some
  // bursts are long enough to give stretches with no gaps at all.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] value, input logic last);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 20);
    end
    rx_byte      = value;
    end_of_frame = last;
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(value, last);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_frame(input byte_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // Stops offering bytes until every owed result has come out, then lets the
  // block settle. Called at a falling edge, after the last byte was accepted.
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (sb.pending_fields.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes both registers back to back, valid held high across the pair.
  task automatic load_settings(input logic [7:0] slave, input logic [7:0] count);
    cfg_index = REG_SLAVE_ADDRESS;
    cfg_data  = slave;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(REG_SLAVE_ADDRESS, slave);
    @(negedge clk);
    cfg_index = REG_REGISTER_COUNT;
    cfg_data  = count;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(REG_REGISTER_COUNT, count);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One random frame for the current settings. Most frames are well formed
  // with random or all-ones content; the rest have a bad CRC, a wrong slave
  // id, a wrong function code, too few bytes, or are pure noise.
  task automatic send_random_frame(output int unsigned sent);
    int unsigned min_len;
    int unsigned len;
    int unsigned pick;
    logic [7:0]  slave;
    byte_q_t     q;
    slave   = sb.slave_addr;
    min_len = FRAME_OVERHEAD + 2 * sb.reg_count;
    // With the largest register counts no frame can be long enough; such
    // frames are still sent at full store length and come back as short.
    len  = (min_len >= STORE_BYTES) ? STORE_BYTES
         : min_len + $urandom_range(0, (STORE_BYTES - min_len < 3) ? STORE_BYTES - min_len : 3);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      q = sealed(frame_body(slave, FUNC_READ_HOLDING, len - 2,
                            (pick < 9) ? FILL_ONES : FILL_RANDOM), 1'b0);
    end else if (pick < 65) begin
      q = sealed(frame_body(slave, FUNC_READ_HOLDING, len - 2, FILL_RANDOM), 1'b1);
    end else if (pick < 73) begin
      q = sealed(frame_body(slave ^ 8'($urandom_range(1, 255)), FUNC_READ_HOLDING,
                            len - 2, FILL_RANDOM), 1'b0);
    end else if (pick < 80) begin
      q = sealed(frame_body(slave, FUNC_READ_HOLDING ^ 8'($urandom_range(1, 255)),
                            len - 2, FILL_RANDOM), 1'b0);
    end else if (pick < 88) begin
      len = $urandom_range(1, min_len - 1);
      if (len >= 4)
        q = sealed(frame_body(slave, FUNC_READ_HOLDING, len - 2, FILL_RANDOM), 1'b0);
      else
        q = noise(len);
    end else begin
      q = noise($urandom_range(1, 10));
    end
    send_frame(q);
    sent = q.size();
    // Now and then the sender waits for the block to drain completely.
    if ($urandom_range(0, 9) == 0) wait_for_results();
  endtask

  task automatic run_phase(input logic [7:0] slave, input logic [7:0] count);
    int unsigned phase_bytes;
    int unsigned frames;
    int unsigned sent;
    wait_for_results();
    load_settings(slave, count);
    phase_bytes = 0;
    frames      = 0;
    while (phase_bytes < PHASE_BYTES || frames < 3) begin
      send_random_frame(sent);
      phase_bytes += sent;
      frames++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result receiver. It switches between stall patterns of random length:
  // always ready, coin toss, ready one time in three, and mostly ready. A
  // long hold-off request from the stimulus makes it refuse results until
  // its LONG_HOLD countdown, kept here, runs out, so the block fills up and
  // stops taking bytes while the sender keeps offering them.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int         stretch_left;
    int         hold_left;
    sink_mode_e mode;
    out_ready    = 1'b0;
    stretch_left = 0;
    hold_left    = 0;
    mode         = SINK_OPEN;
    forever begin
      @(negedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        if (stretch_left == 0) begin
          mode         = sink_mode_e'($urandom_range(0, 3));
          stretch_left = $urandom_range(16, 160);
        end
        stretch_left--;
        case (mode)
          SINK_OPEN:        out_ready = 1'b1;
          SINK_COIN:        out_ready = ($urandom_range(0, 1) == 1);
          SINK_EVERY_THIRD: out_ready = ((stretch_left % 3) == 0);
          default:          out_ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Results are checked at the rising edge where they are handed over.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_field(frame_status, field_id, field_value, last_result);
  end

  // Watchdog: too long without any item moving on any channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    sb           = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    rx_byte      = 8'h00;
    end_of_frame = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_SLAVE_ADDRESS;
    cfg_data     = 8'h00;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Under the reset settings (slave 1, 100 registers) a good frame that
    // fills the store exactly, followed by bytes that are dropped though the
    // last of them still ends the frame. It writes every store byte that any
    // field reads, so later frames with small register counts never read a
    // byte that was not written.
    send_frame({sealed(frame_body(SLAVE_ADDRESS_RST, FUNC_READ_HOLDING, STORE_BYTES - 2,
                                  FILL_RANDOM), 1'b0), noise(4)});
    // A single byte is far too short.
    send_frame('{8'hFF});

    // From here on a register count of zero makes five bytes a full frame,
    // whose fields read bytes left over from earlier frames.
    wait_for_results();
    load_settings(SLAVE_ADDRESS_RST, 8'd0);

    // Long receiver hold-off while two good frames are offered back to back:
    // the second one has to wait until the first frame's results drain.
    holds_asked++;
    send_frame(sealed(frame_body(SLAVE_ADDRESS_RST, FUNC_READ_HOLDING, 6, FILL_RANDOM), 1'b0));
    send_frame(sealed(frame_body(SLAVE_ADDRESS_RST, FUNC_READ_HOLDING, 6, FILL_RANDOM), 1'b0));

    // A frame of exactly the minimum length, and one a byte short of it.
    send_frame(sealed(frame_body(SLAVE_ADDRESS_RST, FUNC_READ_HOLDING, 3, FILL_RANDOM), 1'b0));
    send_frame(sealed(frame_body(SLAVE_ADDRESS_RST, FUNC_READ_HOLDING, 2, FILL_RANDOM), 1'b0));
    // Wrong slave id and wrong function code with good CRCs.
    send_frame(sealed(frame_body(8'h02, FUNC_READ_HOLDING, 6, FILL_RANDOM), 1'b0));
    send_frame(sealed(frame_body(SLAVE_ADDRESS_RST, 8'h04, 6, FILL_RANDOM), 1'b0));
    // A short frame with a bad CRC must report short, not CRC.
    send_frame(sealed(frame_body(SLAVE_ADDRESS_RST, FUNC_READ_HOLDING, 2, FILL_RANDOM), 1'b1));
    // CRC mismatch on an otherwise good frame.
    send_frame(sealed(frame_body(SLAVE_ADDRESS_RST, FUNC_READ_HOLDING, 6, FILL_RANDOM), 1'b1));

    // Random frames under a series of settings with small register counts,
    // extreme slave ids included. The top bit of the count byte is ignored
    // by the block, so 8'h80 acts as a count of zero.
    run_phase(8'hFF, 8'h80);
    run_phase(8'($urandom), 8'($urandom_range(1, 3)));
    run_phase(8'h00, 8'd0);
    run_phase(SLAVE_ADDRESS_RST, 8'h80 | 8'($urandom_range(1, 2)));

    wait_for_results();
    if (sb.fault_count == 0 && sb.pending_fields.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/mrfe_pkg.sv
hdl/mrfe_store.sv
hdl/mrfe_intake.sv
hdl/mrfe_extract.sv
hdl/modbus_read_response_field_extractor.sv
verif/modbus_read_response_field_extractor_tb.sv
